### src/tmx_pkg.sv
// tmx_pkg: shared types and constants of the tank mixer with slew limit
package tmx_pkg;

    localparam logic [11:0] CENTRE       = 12'd1500;
    localparam logic [11:0] SW_LOW_EDGE  = 12'd1450;
    localparam logic [11:0] SW_HIGH_EDGE = 12'd1550;

    // x / 200 == ((x >> 3) * 5243) >> 17 for x >> 3 below 43690
    localparam int          DIV8_SHIFT   = 3;
    localparam logic [12:0] DIV25_MUL    = 13'd5243;
    localparam int          DIV25_SHIFT  = 17;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_DRIVE_SLEW     = 3'd0,
        REG_PUMP_SLEW      = 3'd1,
        REG_PUMP_FLOOR     = 3'd2,
        REG_PUMP_CEILING   = 3'd3,
        REG_DRIVE_DEADBAND = 3'd4,
        REG_DRIVE_CEILING  = 3'd5,
        REG_VALVE_DEADZONE = 3'd6,
        REG_VALVE_GAIN     = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        BLINK_OFF    = 3'd0,
        BLINK_LEFT   = 3'd1,
        BLINK_RIGHT  = 3'd2,
        BLINK_HAZARD = 3'd3,
        BLINK_STROBE = 3'd4
    } t_blink;

    typedef enum logic [1:0] {
        SW_LOW  = 2'd0,
        SW_MID  = 2'd1,
        SW_HIGH = 2'd2
    } t_sw;

    typedef struct packed {
        logic [11:0] valve_a_pulse;
        logic [11:0] valve_b_pulse;
        logic [11:0] throttle_pulse;
        logic [11:0] steer_pulse;
        logic [11:0] valve_c_pulse;
        logic [11:0] light_switch_pulse;
        logic [11:0] hazard_switch_pulse;
    } t_in_word;

    typedef struct packed {
        logic [10:0] left_drive_pulse;
        logic [10:0] right_drive_pulse;
        logic [10:0] pump_pulse;
        logic [2:0]  blink_mode;
        logic        blink_changed;
        logic        reverse_light;
        logic        aux_light;
        logic        pump_active;
    } t_out_word;

    typedef struct packed {
        logic [8:0] drive_slew;
        logic [8:0] pump_slew;
        logic [8:0] pump_floor;
        logic [8:0] pump_ceiling;
        logic [7:0] drive_deadband;
        logic [8:0] drive_ceiling;
        logic [8:0] valve_deadzone;
        logic [6:0] valve_gain_percent;
    } t_cfg;

endpackage

### src/tmx_if.sv
// tmx_if: valid/ready channels for input and result words
interface tmx_in_if;
    logic              valid;
    logic              ready;
    tmx_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmx_out_if;
    logic               valid;
    logic               ready;
    tmx_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/tank_mixer_with_slew_limit_unit.sv
// tank_mixer_with_slew_limit_unit: tank drive mixer, pump mixer and blink mode, top level
//
// i_item carries one frame of seven rc pulse widths; o_result carries the
// left and right drive pulses, pump pulse, blink mode and light flags.
// both are valid/ready channels; a word moves when valid and ready are high.
// an accepted input passes the input register, which holds the valve
// products, and then the result register, which holds the word.
// throughput is one word per cycle while o_result.ready is high; the slew
// and blink state feeding back between frames is updated as the word enters
// the result register. when o_result.ready is low the result holds and one
// more word is taken into the input register, then i_item.ready drops.
// the apb port writes the eight settings at byte address 4*index; pready is
// always high. settings must be changed only while no word is in flight;
// the block does not enforce this. i_rst_n (synchronous, active low) empties
// both registers, clears the last-output state so the first frame is not
// slew limited, and loads the default settings.
module tank_mixer_with_slew_limit_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tmx_in_if.sink                     i_item,
    tmx_out_if.source                  o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tmx_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef struct packed {
        logic [18:0]        prod_a;
        logic [18:0]        prod_b;
        logic [18:0]        prod_c;
        logic signed [12:0] thr;
        logic signed [12:0] str;
        logic               aux;
        tmx_pkg::t_sw       hazard;
    } t_stage;

    tmx_pkg::t_cfg      r_cfg;
    logic               r_a_valid;
    t_stage             r_a;
    t_stage             n_a;
    logic               r_o_valid;
    tmx_pkg::t_out_word r_o;
    tmx_pkg::t_out_word n_o;
    logic [10:0]        r_left_last;
    logic [10:0]        r_right_last;
    logic [10:0]        r_pump_last;
    tmx_pkg::t_blink    r_blink_last;
    tmx_pkg::t_blink    n_blink;

    logic out_take;
    logic a_move;
    logic in_take;
    logic cfg_wr;

    logic [10:0]        q_a;
    logic [10:0]        q_b;
    logic [10:0]        q_c;
    logic [12:0]        demand;
    logic [13:0]        pump_v;
    logic [11:0]        pump_tgt;
    logic [11:0]        left_tgt;
    logic [11:0]        right_tgt;

    function automatic tmx_pkg::t_sw switch_pos(input logic [11:0] p);
        tmx_pkg::t_sw s;
        if (p < tmx_pkg::SW_LOW_EDGE) begin
            s = tmx_pkg::SW_LOW;
        end else if (p > tmx_pkg::SW_HIGH_EDGE) begin
            s = tmx_pkg::SW_HIGH;
        end else begin
            s = tmx_pkg::SW_MID;
        end
        return s;
    endfunction

    function automatic logic [18:0] valve_prod(input logic [11:0] p, input logic [8:0] dz,
                                               input logic [6:0] gain);
        logic [11:0] d;
        logic [11:0] excess;
        d = (p < tmx_pkg::CENTRE) ? tmx_pkg::CENTRE - p : p - tmx_pkg::CENTRE;
        if (d < {3'b000, dz}) begin
            excess = 12'd0;
        end else begin
            excess = d - {3'b000, dz};
        end
        return {7'd0, excess} * {12'd0, gain};
    endfunction

    function automatic logic [10:0] div200(input logic [18:0] x);
        logic [15:0] y;
        logic [28:0] prod;
        y    = x[18:tmx_pkg::DIV8_SHIFT];
        prod = {13'd0, y} * {16'd0, tmx_pkg::DIV25_MUL};
        return prod[tmx_pkg::DIV25_SHIFT +: 11];
    endfunction

    function automatic logic [11:0] drive_target(input logic signed [13:0] m,
                                                 input logic [7:0] db, input logic [8:0] cl);
        logic signed [13:0] sdb;
        logic signed [13:0] scl;
        logic signed [13:0] sum;
        logic [11:0]        t;
        sdb = $signed({6'd0, db});
        scl = $signed({5'd0, cl});
        sum = $signed({2'b00, tmx_pkg::CENTRE}) + m;
        if (m > -sdb && m < sdb) begin
            t = tmx_pkg::CENTRE;
        end else if (m < -scl) begin
            t = tmx_pkg::CENTRE - {3'b000, cl};
        end else if (m > scl) begin
            t = tmx_pkg::CENTRE + {3'b000, cl};
        end else begin
            t = sum[11:0];
        end
        return t;
    endfunction

    function automatic logic [10:0] slew(input logic [11:0] target, input logic [10:0] last,
                                         input logic [8:0] step);
        logic signed [12:0] lim;
        logic signed [12:0] st;
        logic [10:0]        res;
        st  = $signed({1'b0, target});
        res = target[10:0];
        if (last != 11'd0 && step != 9'd0) begin
            if (target < tmx_pkg::CENTRE) begin
                lim = $signed({2'b00, last}) - $signed({4'd0, step});
                if (lim > $signed({1'b0, tmx_pkg::SW_LOW_EDGE})) begin
                    lim = $signed({1'b0, tmx_pkg::SW_LOW_EDGE});
                end
                if (st < lim) begin
                    res = lim[10:0];
                end
            end else begin
                lim = $signed({2'b00, last}) + $signed({4'd0, step});
                if (lim < $signed({1'b0, tmx_pkg::SW_HIGH_EDGE})) begin
                    lim = $signed({1'b0, tmx_pkg::SW_HIGH_EDGE});
                end
                if (st > lim) begin
                    res = lim[10:0];
                end
            end
        end
        return res;
    endfunction

    // handshake
    assign out_take       = r_o_valid && o_result.ready;
    assign a_move         = r_a_valid && (!r_o_valid || out_take);
    assign i_item.ready   = !r_a_valid || a_move;
    assign in_take        = i_item.valid && i_item.ready;
    assign o_result.valid = r_o_valid;
    assign o_result.data  = r_o;

    // input stage: valve products, centred sticks and switch positions
    always_comb begin
        n_a.prod_a = valve_prod(i_item.data.valve_a_pulse, r_cfg.valve_deadzone,
                                r_cfg.valve_gain_percent);
        n_a.prod_b = valve_prod(i_item.data.valve_b_pulse, r_cfg.valve_deadzone,
                                r_cfg.valve_gain_percent);
        n_a.prod_c = valve_prod(i_item.data.valve_c_pulse, r_cfg.valve_deadzone,
                                r_cfg.valve_gain_percent);
        n_a.thr    = $signed({1'b0, i_item.data.throttle_pulse})
                     - $signed({1'b0, tmx_pkg::CENTRE});
        n_a.str    = $signed({1'b0, i_item.data.steer_pulse})
                     - $signed({1'b0, tmx_pkg::CENTRE});
        n_a.aux    = switch_pos(i_item.data.light_switch_pulse) != tmx_pkg::SW_LOW;
        n_a.hazard = switch_pos(i_item.data.hazard_switch_pulse);
    end

    // result stage
    always_comb begin
        q_a    = div200(r_a.prod_a);
        q_b    = div200(r_a.prod_b);
        q_c    = div200(r_a.prod_c);
        demand = {2'b00, q_a} + {2'b00, q_b} + {2'b00, q_c};
        pump_v = {1'b0, demand} + {5'd0, r_cfg.pump_floor};
        if (pump_v > {5'd0, r_cfg.pump_ceiling}) begin
            pump_v = {5'd0, r_cfg.pump_ceiling};
        end
        if (demand == 13'd0) begin
            pump_tgt = tmx_pkg::CENTRE;
        end else begin
            pump_tgt = tmx_pkg::CENTRE + {3'b000, pump_v[8:0]};
        end
        left_tgt  = drive_target(14'(r_a.thr) + 14'(r_a.str),
                                 r_cfg.drive_deadband, r_cfg.drive_ceiling);
        right_tgt = drive_target(14'(r_a.thr) - 14'(r_a.str),
                                 r_cfg.drive_deadband, r_cfg.drive_ceiling);
    end

    always_comb begin
        n_blink = r_blink_last;
        case (r_a.hazard)
            tmx_pkg::SW_MID: begin
                n_blink = tmx_pkg::BLINK_HAZARD;
            end
            tmx_pkg::SW_HIGH: begin
                n_blink = tmx_pkg::BLINK_STROBE;
            end
            default: begin
                if (r_a.thr < -13'sd100 || (r_a.str > -13'sd50 && r_a.str < 13'sd50)) begin
                    n_blink = tmx_pkg::BLINK_OFF;
                end else if (r_a.thr > -13'sd50) begin
                    if (r_a.str < -13'sd250) begin
                        n_blink = tmx_pkg::BLINK_LEFT;
                    end else if (r_a.str > 13'sd250) begin
                        n_blink = tmx_pkg::BLINK_RIGHT;
                    end
                end
            end
        endcase
    end

    always_comb begin
        n_o.left_drive_pulse  = slew(left_tgt, r_left_last, r_cfg.drive_slew);
        n_o.right_drive_pulse = slew(right_tgt, r_right_last, r_cfg.drive_slew);
        n_o.pump_pulse        = slew(pump_tgt, r_pump_last, r_cfg.pump_slew);
        n_o.blink_mode        = n_blink;
        n_o.blink_changed     = n_blink != r_blink_last;
        n_o.reverse_light     = r_a.thr < -13'sd50;
        n_o.aux_light         = r_a.aux;
        n_o.pump_active       = demand != 13'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
            r_left_last  <= 11'd0;
            r_right_last <= 11'd0;
            r_pump_last  <= 11'd0;
            r_blink_last <= tmx_pkg::BLINK_OFF;
        end else begin
            if (in_take) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_o_valid    <= 1'b1;
                r_left_last  <= n_o.left_drive_pulse;
                r_right_last <= n_o.right_drive_pulse;
                r_pump_last  <= n_o.pump_pulse;
                r_blink_last <= n_blink;
            end else if (out_take) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a <= n_a;
        end
        if (a_move) begin
            r_o <= n_o;
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_slew         <= 9'd20;
            r_cfg.pump_slew          <= 9'd20;
            r_cfg.pump_floor         <= 9'd60;
            r_cfg.pump_ceiling       <= 9'd300;
            r_cfg.drive_deadband     <= 8'd50;
            r_cfg.drive_ceiling      <= 9'd500;
            r_cfg.valve_deadzone     <= 9'd80;
            r_cfg.valve_gain_percent <= 7'd50;
        end else if (cfg_wr) begin
            case (tmx_pkg::t_reg_idx'(paddr[4:2]))
                tmx_pkg::REG_DRIVE_SLEW:     r_cfg.drive_slew         <= pwdata[8:0];
                tmx_pkg::REG_PUMP_SLEW:      r_cfg.pump_slew          <= pwdata[8:0];
                tmx_pkg::REG_PUMP_FLOOR:     r_cfg.pump_floor         <= pwdata[8:0];
                tmx_pkg::REG_PUMP_CEILING:   r_cfg.pump_ceiling       <= pwdata[8:0];
                tmx_pkg::REG_DRIVE_DEADBAND: r_cfg.drive_deadband     <= pwdata[7:0];
                tmx_pkg::REG_DRIVE_CEILING:  r_cfg.drive_ceiling      <= pwdata[8:0];
                tmx_pkg::REG_VALVE_DEADZONE: r_cfg.valve_deadzone     <= pwdata[8:0];
                tmx_pkg::REG_VALVE_GAIN:     r_cfg.valve_gain_percent <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (tmx_pkg::t_reg_idx'(paddr[4:2]))
            tmx_pkg::REG_DRIVE_SLEW:     prdata = {23'd0, r_cfg.drive_slew};
            tmx_pkg::REG_PUMP_SLEW:      prdata = {23'd0, r_cfg.pump_slew};
            tmx_pkg::REG_PUMP_FLOOR:     prdata = {23'd0, r_cfg.pump_floor};
            tmx_pkg::REG_PUMP_CEILING:   prdata = {23'd0, r_cfg.pump_ceiling};
            tmx_pkg::REG_DRIVE_DEADBAND: prdata = {24'd0, r_cfg.drive_deadband};
            tmx_pkg::REG_DRIVE_CEILING:  prdata = {23'd0, r_cfg.drive_ceiling};
            tmx_pkg::REG_VALVE_DEADZONE: prdata = {23'd0, r_cfg.valve_deadzone};
            tmx_pkg::REG_VALVE_GAIN:     prdata = {25'd0, r_cfg.valve_gain_percent};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

### src/tmx_chk.sv
// tmx_chk: port-level assertions for the tank mixer, bound to the top level
module tmx_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input tmx_pkg::t_out_word i_word
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_word))
        else $error("result word changed while stalled");

    // idle pump always settles on centre, slew never holds it off
    a_pump_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_word.pump_active |-> i_word.pump_pulse == 11'd1500)
        else $error("pump not centred without demand");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_word.left_drive_pulse >= 11'd989 && i_word.left_drive_pulse <= 11'd2011
                 && i_word.right_drive_pulse >= 11'd989
                 && i_word.right_drive_pulse <= 11'd2011)
        else $error("drive pulse outside clamp range");

endmodule

bind tank_mixer_with_slew_limit_unit tmx_chk u_tmx_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_word  (o_result.data)
);
